// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks with reset masking, same-cycle and next-cycle forms
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define WPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wpm_pkg.sv =====
// ---------------------------------------------------------------------------
// wpm_pkg
// shared constants, register codes and status types of the power meter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  // default configuration
  localparam int WPM_WINDOW      = 1000;
  localparam int WPM_SAMPLE_BITS = 12;

  // fixed field widths
  localparam int MEAN_W    = 12;  // mean in mv stays below 3300
  localparam int GAIN_W    = 16;
  localparam int UNIT_W    = 16;
  localparam int POWER_W   = 23;
  localparam int Q_FRAC    = 8;   // q8.8 gains
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [MEAN_W-1:0]  FULL_SCALE_MV = 12'd3300;
  localparam logic [UNIT_W-1:0]  UNIT_MAX      = 16'hFFFF;
  localparam logic [POWER_W-1:0] POWER_MAX     = 23'd4294967;
  localparam int                 POWER_DIV     = 1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = 2'd2;

  // register reset values
  localparam logic [11:0]       DIVIDER_GAIN_RST   = 12'd1420;
  localparam logic [MEAN_W-1:0] CURRENT_OFFSET_RST = 12'd2580;
  localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST   = 16'd1384;

  typedef struct packed {
    logic              done;
    logic [UNIT_W-1:0] value;
  } lane_stat_t;

  typedef struct packed {
    logic               done;
    logic [POWER_W-1:0] power;
  } merge_stat_t;

endpackage

`default_nettype wire

// ===== sv/wpm_in_if.sv =====
// ---------------------------------------------------------------------------
// wpm_in_if
// sample pair channel, valid/ready handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wpm_in_if import wpm_pkg::*; #(
  parameter int SAMPLE_BITS = WPM_SAMPLE_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] current_sample;
  logic [SAMPLE_BITS-1:0] voltage_sample;

  modport source (output valid, output current_sample, output voltage_sample,
                  input ready);
  modport sink   (input valid, input current_sample, input voltage_sample,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/wpm_out_if.sv =====
// ---------------------------------------------------------------------------
// wpm_out_if
// measurement channel, valid/ready handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wpm_out_if import wpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [UNIT_W-1:0]  voltage_mv;
  logic [UNIT_W-1:0]  current_ma;
  logic [POWER_W-1:0] power_mw;

  modport source (output valid, output voltage_mv, output current_ma,
                  output power_mw, input ready);
  modport sink   (input valid, input voltage_mv, input current_ma,
                  input power_mw, output ready);
endinterface

`default_nettype wire

// ===== sv/wpm_line_store.sv =====
// ---------------------------------------------------------------------------
// wpm_line_store
// single-port-write, registered-read sample pair memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpm_line_store import wpm_pkg::*; #(
  parameter int DEPTH = WPM_WINDOW,
  parameter int WIDTH = 2 * WPM_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/wpm_lane.sv =====
// ---------------------------------------------------------------------------
// wpm_lane
// one channel: running sum, mean in mv, offset removal and saturating gain scaling
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpm_lane import wpm_pkg::*; #(
  parameter int WINDOW      = WPM_WINDOW,
  parameter int SAMPLE_BITS = WPM_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] old_sample,
  input  logic [MEAN_W-1:0]      offset,
  input  logic [GAIN_W-1:0]      gain,
  output lane_stat_t             stat
);

  localparam int WIN_W      = $clog2(WINDOW);
  localparam int SUM_W      = WIN_W + SAMPLE_BITS;
  localparam int PROD_W     = SUM_W + MEAN_W;
  localparam int Y_W        = WIN_W + MEAN_W;
  localparam int SCALED_W   = MEAN_W + GAIN_W;
  // floor(y / window) as (y * rec) >> rec_s, exact for every y below 2^y_w
  localparam int REC_S      = Y_W + WIN_W;
  localparam int REC_W      = Y_W + 1;
  localparam int REC_PROD_W = Y_W + REC_W;
  localparam longint unsigned REC_FULL =
    ((64'd1 << REC_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [REC_W-1:0] REC_M = REC_W'(REC_FULL);

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_DIV, L_OFF, L_GAIN, L_SAT
  } lane_state_t;

  lane_state_t          state;
  logic [SUM_W-1:0]     sum;
  logic [Y_W-1:0]       rem;
  logic [MEAN_W-1:0]    quo;
  logic [MEAN_W-1:0]    diff;
  logic [SCALED_W-1:0]  scaled;
  logic                 done;
  logic [UNIT_W-1:0]    value;

  logic [PROD_W-1:0]    prod;
  logic [REC_PROD_W-1:0] rec_prod;
  logic [UNIT_W-1:0]    value_next;

  assign prod     = PROD_W'(sum) * PROD_W'(FULL_SCALE_MV);
  assign rec_prod = REC_PROD_W'(rem) * REC_PROD_W'(REC_M);

  // drop the q8.8 fraction, saturate to 16 bits
  assign value_next = (|scaled[SCALED_W-1:Q_FRAC+UNIT_W]) ? UNIT_MAX
                                                           : scaled[Q_FRAC+UNIT_W-1:Q_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            sum   <= sum - SUM_W'(old_sample) + SUM_W'(sample);
            state <= L_MUL;
          end
        end
        L_MUL: begin
          // floor by 2^sample_bits here, by window in the next step
          rem   <= prod[PROD_W-1:SAMPLE_BITS];
          state <= L_DIV;
        end
        L_DIV: begin
          // reciprocal multiply, quotient stays below 3300
          quo   <= rec_prod[REC_S +: MEAN_W];
          state <= L_OFF;
        end
        L_OFF: begin
          diff  <= (quo > offset) ? quo - offset : '0;
          state <= L_GAIN;
        end
        L_GAIN: begin
          scaled <= SCALED_W'(diff) * SCALED_W'(gain);
          state  <= L_SAT;
        end
        L_SAT: begin
          value <= value_next;
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  assign stat.done  = done;
  assign stat.value = value;

endmodule

`default_nettype wire

// ===== sv/wpm_merge.sv =====
// ---------------------------------------------------------------------------
// wpm_merge
// combines lane results: power = voltage * current / 1000, saturated
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpm_merge import wpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [UNIT_W-1:0] volt,
  input  logic [UNIT_W-1:0] cur,
  output merge_stat_t       stat
);

  localparam int PROD_W     = 2 * UNIT_W;
  // 1000 = 8 * 125: shift out the power of two, reciprocal multiply by 1/125
  localparam int PRE_SHIFT  = 3;
  localparam int ODD_DIV    = POWER_DIV >> PRE_SHIFT;
  localparam int X_W        = PROD_W - PRE_SHIFT;
  localparam int REC_S      = X_W + $clog2(ODD_DIV);
  localparam int REC_W      = X_W + 1;
  localparam int REC_PROD_W = X_W + REC_W;
  localparam longint unsigned REC_FULL =
    ((64'd1 << REC_S) + 64'(ODD_DIV) - 64'd1) / 64'(ODD_DIV);
  localparam logic [REC_W-1:0] REC_M = REC_W'(REC_FULL);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_SAT} merge_state_t;

  merge_state_t          state;
  logic [UNIT_W-1:0]     volt_q;
  logic [UNIT_W-1:0]     cur_q;
  logic [PROD_W-1:0]     prod;
  logic [POWER_W-1:0]    quo;
  logic                  done;
  logic [POWER_W-1:0]    power;
  logic [REC_PROD_W-1:0] rec_prod;

  assign rec_prod = REC_PROD_W'(prod[PROD_W-1:PRE_SHIFT]) * REC_PROD_W'(REC_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            volt_q <= volt;
            cur_q  <= cur;
            state  <= M_MUL;
          end
        end
        M_MUL: begin
          prod  <= PROD_W'(volt_q) * PROD_W'(cur_q);
          state <= M_DIV;
        end
        M_DIV: begin
          // quotient of a 32-bit product by 1000 fits in 23 bits
          quo   <= rec_prod[REC_S +: POWER_W];
          state <= M_SAT;
        end
        M_SAT: begin
          power <= (quo > POWER_MAX) ? POWER_MAX : quo;
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  assign stat.done  = done;
  assign stat.power = power;

endmodule

`default_nettype wire

// ===== sv/windowed_power_meter.sv =====
// ---------------------------------------------------------------------------
// windowed_power_meter
// sliding-mean power meter for a current-sensor and a voltage-divider channel
// ---------------------------------------------------------------------------
// channel   dir   fields                                   handshake
// samples   in    current_sample, voltage_sample           valid/ready
// results   out   voltage_mv, current_ma, power_mw         valid/ready
// cfg       in    cfg_index, cfg_data                      cfg_we, no wait
//
// a new word is taken only once the last reading is in the output register;
// after the accept it passes the read state, six lane steps (sum, scale,
// reciprocal multiply by 1/window, offset, gain, saturate) and four merge
// steps before it is loaded; the schedule does not depend on window
// reset is synchronous; the line store is not cleared, a wrap flag masks
// entries not yet written so the first window averages zeros
// a finished word waits in the output register while the next word is taken;
// if the output is still full when that one finishes, the block holds it and
// stops taking words until the sink takes the old word, loading it in that same cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module windowed_power_meter import wpm_pkg::*; #(
  parameter int WINDOW      = WPM_WINDOW,
  parameter int SAMPLE_BITS = WPM_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  wpm_in_if.sink               samples,
  wpm_out_if.source            results,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int PAIR_W = 2 * SAMPLE_BITS;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LANES, S_MERGE, S_PARK} state_t;

  state_t                 state;
  logic [PTR_W-1:0]       ptr;       // oldest entry, overwritten next
  logic                   wrapped;   // every entry has been written once
  logic [SAMPLE_BITS-1:0] cs;
  logic [SAMPLE_BITS-1:0] vs;
  logic                   out_valid;
  logic [UNIT_W-1:0]      out_volt;
  logic [UNIT_W-1:0]      out_cur;
  logic [POWER_W-1:0]     out_power;

  // configuration registers
  logic [11:0]            divider_gain;
  logic [MEAN_W-1:0]      current_offset_mv;
  logic [GAIN_W-1:0]      current_gain;

  logic                   accept;
  logic                   lane_start;
  logic                   merge_start;
  logic                   slot_free;
  logic                   out_load;
  logic [PAIR_W-1:0]      rdata;
  logic [SAMPLE_BITS-1:0] old_cur;
  logic [SAMPLE_BITS-1:0] old_volt;
  lane_stat_t             c_stat;
  lane_stat_t             v_stat;
  merge_stat_t            m_stat;

  assign accept      = samples.valid && samples.ready;
  assign lane_start  = (state == S_READ);
  assign merge_start = (state == S_LANES) && c_stat.done;
  assign slot_free   = !out_valid || results.ready;
  assign out_load    = (((state == S_MERGE) && m_stat.done) || (state == S_PARK))
                       && slot_free;

  // before the first wrap the entry at ptr was never written: it counts as zero
  assign old_cur  = wrapped ? rdata[PAIR_W-1:SAMPLE_BITS] : '0;
  assign old_volt = wrapped ? rdata[SAMPLE_BITS-1:0]      : '0;

  // line store, read at ptr every cycle, written back in the read state
  wpm_line_store #(
    .DEPTH (WINDOW),
    .WIDTH (PAIR_W)
  ) u_line (
    .clk   (clk),
    .we    (lane_start),
    .waddr (ptr),
    .wdata ({cs, vs}),
    .raddr (ptr),
    .rdata (rdata)
  );

  // current lane: offset removed, negatives clamped
  wpm_lane #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cur_lane (
    .clk        (clk),
    .rst        (rst),
    .start      (lane_start),
    .sample     (cs),
    .old_sample (old_cur),
    .offset     (current_offset_mv),
    .gain       (current_gain),
    .stat       (c_stat)
  );

  // voltage lane: no offset, divider gain
  wpm_lane #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_volt_lane (
    .clk        (clk),
    .rst        (rst),
    .start      (lane_start),
    .sample     (vs),
    .old_sample (old_volt),
    .offset     ('0),
    .gain       (GAIN_W'(divider_gain)),
    .stat       (v_stat)
  );

  wpm_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (merge_start),
    .volt  (v_stat.value),
    .cur   (c_stat.value),
    .stat  (m_stat)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_volt  <= v_stat.value;
        out_cur   <= c_stat.value;
        out_power <= m_stat.power;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cs    <= samples.current_sample;
            vs    <= samples.voltage_sample;
            state <= S_READ;
          end
        end
        S_READ: begin
          // oldest pair is in rdata now, lanes take it
          if (ptr == PTR_W'(WINDOW - 1)) begin
            ptr     <= '0;
            wrapped <= 1'b1;
          end else begin
            ptr <= ptr + 1'b1;
          end
          state <= S_LANES;
        end
        S_LANES: begin
          if (c_stat.done) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (m_stat.done) begin
            state <= slot_free ? S_IDLE : S_PARK;
          end
        end
        S_PARK: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_gain      <= DIVIDER_GAIN_RST;
      current_offset_mv <= CURRENT_OFFSET_RST;
      current_gain      <= CURRENT_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIVIDER_GAIN:   divider_gain      <= cfg_data[11:0];
        REG_CURRENT_OFFSET: current_offset_mv <= cfg_data[MEAN_W-1:0];
        REG_CURRENT_GAIN:   current_gain      <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign samples.ready      = (state == S_IDLE);
  assign results.valid      = out_valid;
  assign results.voltage_mv = out_volt;
  assign results.current_ma = out_cur;
  assign results.power_mw   = out_power;

  // both lanes run the same schedule
  `WPM_ASSERT_SAME(a_lanes_in_step, clk, rst, 1'b1, c_stat.done == v_stat.done, "lanes out of step")
  // merge result only arrives while the sequencer waits for it
  `WPM_ASSERT_SAME(a_merge_done_state, clk, rst, m_stat.done, state == S_MERGE, "stray merge done")
  // pointer moves only when a pair is written back
  `WPM_ASSERT_NEXT(a_ptr_hold, clk, rst, state != S_READ, $stable(ptr), "pointer moved outside read")
  // once wrapped, every entry stays valid
  `WPM_ASSERT_NEXT(a_wrap_sticky, clk, rst, wrapped, wrapped, "wrap flag dropped")
  // a new word only comes out of the merge or park states
  `WPM_ASSERT_SAME(a_out_source, clk, rst, $rose(out_valid), $past(state) == S_MERGE || $past(state) == S_PARK, "output loaded out of sequence")

endmodule

`default_nettype wire
